/* sv/cau_pkg.sv */
// cau_pkg: shared types and constants of the 16-bit flags ALU.
// Used by cau_mul, cau_alu, the top level and its checker.
package cau_pkg;

   typedef enum logic [4:0] {
      OP_LSR   = 5'd0,
      OP_ROL   = 5'd1,
      OP_ROR   = 5'd2,
      OP_ASR   = 5'd3,
      OP_DIV2  = 5'd4,
      OP_ADD   = 5'd5,
      OP_ADC   = 5'd6,
      OP_SUB   = 5'd7,
      OP_SBC   = 5'd8,
      OP_CMP   = 5'd9,
      OP_AND   = 5'd10,
      OP_BIC   = 5'd11,
      OP_OR    = 5'd12,
      OP_XOR   = 5'd13,
      OP_NOT   = 5'd14,
      OP_SWAP  = 5'd15,
      OP_SEX   = 5'd16,
      OP_LOB   = 5'd17,
      OP_HIB   = 5'd18,
      OP_MRG   = 5'd19,
      OP_MULT  = 5'd20,
      OP_MULU  = 5'd21,
      OP_FMULT = 5'd22,
      OP_LMULT = 5'd23
   } alu_op_type;

   localparam logic [15:0] MERGE_OV_MASK = 16'hc0c0;
   localparam logic [15:0] MERGE_S_MASK  = 16'h8080;
   localparam logic [15:0] MERGE_CY_MASK = 16'he0e0;
   localparam logic [15:0] MERGE_Z_MASK  = 16'hf0f0;
   localparam logic [15:0] HIGH_BYTE_MASK = 16'hff00;

   typedef struct packed {
      logic [4:0]  req_type;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  imm_value;
      logic        use_imm;
      logic        carry_in;
      logic        overflow_in;
   } cau_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic        write_result;
      logic [15:0] low_product;
      logic        write_low;
      logic        sign_flag;
      logic        zero_flag;
      logic        carry_flag;
      logic        overflow_flag;
   } cau_rsp_type;

endpackage

/* sv/cau_mul.sv */
// cau_mul: shared signed 17x17 multiplier for mult, umult, fmult and lmult.
// Depends on cau_pkg for the operation codes.
module cau_mul
   import cau_pkg::*;
(
   input  alu_op_type  op,
   input  logic [15:0] opnd_a,
   input  logic [15:0] opnd_b,
   input  logic [15:0] opnd_rb,
   output logic [31:0] product
);

   logic        wide;
   logic [16:0] mul_x;
   logic [16:0] mul_y;
   logic [33:0] prod_full;

   always_comb begin
      wide = (op == OP_FMULT) || (op == OP_LMULT);
      if (wide) begin
         mul_x = {opnd_a[15], opnd_a};
         mul_y = {opnd_rb[15], opnd_rb};
      end else if (op == OP_MULU) begin
         mul_x = {9'b0, opnd_a[7:0]};
         mul_y = {9'b0, opnd_b[7:0]};
      end else begin
         mul_x = {{9{opnd_a[7]}}, opnd_a[7:0]};
         mul_y = {{9{opnd_b[7]}}, opnd_b[7:0]};
      end
      prod_full = 34'($signed(mul_x) * $signed(mul_y));
      product = prod_full[31:0];
   end

endmodule

/* sv/cau_alu.sv */
// cau_alu: combinational datapath and flag logic for one ALU word.
// Depends on cau_pkg and instantiates cau_mul.
module cau_alu
   import cau_pkg::*;
(
   input  cau_req_type req,
   output cau_rsp_type rsp
);

   alu_op_type  op;
   logic [15:0] a;
   logic [15:0] b;
   logic [31:0] product;

   assign op = alu_op_type'(req.req_type);
   assign a  = req.operand_a;
   assign b  = req.use_imm ? {12'b0, req.imm_value} : req.operand_b;

   cau_mul u_mul (
      .op      (op),
      .opnd_a  (a),
      .opnd_b  (b),
      .opnd_rb (req.operand_b),
      .product (product)
   );

   logic [16:0] sum;
   logic [16:0] diff;
   logic [15:0] sub_b;
   logic        borrow;
   logic [15:0] r;
   logic [15:0] lowp;
   logic        cy;
   logic        ov;
   logic        wr;
   logic        wl;
   logic        byte_sign;
   logic        merge;
   logic        undef;

   always_comb begin
      sum    = {1'b0, a} + {1'b0, b} + {16'b0, (op == OP_ADC) & req.carry_in};
      sub_b  = (op == OP_CMP) ? req.operand_b : b;
      borrow = (op == OP_SBC) ? ~req.carry_in : 1'b0;
      diff   = {1'b0, a} - {1'b0, sub_b} - {16'b0, borrow};

      r         = '0;
      lowp      = '0;
      cy        = req.carry_in;
      ov        = req.overflow_in;
      wr        = 1'b1;
      wl        = 1'b0;
      byte_sign = 1'b0;
      merge     = 1'b0;
      undef     = 1'b0;

      case (op)
         OP_LSR: begin
            cy = a[0];
            r  = {1'b0, a[15:1]};
         end
         OP_ROL: begin
            r  = {a[14:0], req.carry_in};
            cy = a[15];
         end
         OP_ROR: begin
            r  = {req.carry_in, a[15:1]};
            cy = a[0];
         end
         OP_ASR, OP_DIV2: begin
            cy = a[0];
            r  = {a[15], a[15:1]};
            if (op == OP_DIV2 && a == 16'hffff) begin
               r = '0;
            end
         end
         OP_ADD, OP_ADC: begin
            r  = sum[15:0];
            ov = (a[15] ^ r[15]) & (b[15] ^ r[15]);
            cy = sum[16];
         end
         OP_SUB, OP_SBC, OP_CMP: begin
            r  = diff[15:0];
            ov = (a[15] ^ sub_b[15]) & (a[15] ^ r[15]);
            cy = ~diff[16];
            wr = (op != OP_CMP);
         end
         OP_AND:  r = a & b;
         OP_BIC:  r = a & ~b;
         OP_OR:   r = a | b;
         OP_XOR:  r = a ^ b;
         OP_NOT:  r = ~a;
         OP_SWAP: r = {a[7:0], a[15:8]};
         OP_SEX:  r = {{8{a[7]}}, a[7:0]};
         OP_LOB: begin
            r         = {8'b0, a[7:0]};
            byte_sign = 1'b1;
         end
         OP_HIB: begin
            r         = {8'b0, a[15:8]};
            byte_sign = 1'b1;
         end
         OP_MRG: begin
            r     = (a & HIGH_BYTE_MASK) | {8'b0, req.operand_b[15:8]};
            merge = 1'b1;
         end
         OP_MULT, OP_MULU: r = product[15:0];
         OP_FMULT, OP_LMULT: begin
            r  = product[31:16];
            cy = product[15];
            if (op == OP_LMULT) begin
               lowp = product[15:0];
               wl   = 1'b1;
            end
         end
         default: begin
            undef = 1'b1;
            wr    = 1'b0;
         end
      endcase

      rsp.result       = r;
      rsp.write_result = wr;
      rsp.low_product  = lowp;
      rsp.write_low    = wl;
      if (undef) begin
         rsp.sign_flag     = 1'b0;
         rsp.zero_flag     = 1'b0;
         rsp.carry_flag    = cy;
         rsp.overflow_flag = ov;
      end else if (merge) begin
         rsp.sign_flag     = |(r & MERGE_S_MASK);
         rsp.zero_flag     = |(r & MERGE_Z_MASK);
         rsp.carry_flag    = |(r & MERGE_CY_MASK);
         rsp.overflow_flag = |(r & MERGE_OV_MASK);
      end else begin
         rsp.sign_flag     = byte_sign ? r[7] : r[15];
         rsp.zero_flag     = (r == 16'h0000);
         rsp.carry_flag    = cy;
         rsp.overflow_flag = ov;
      end
   end

endmodule

/* sv/coprocessor_alu_16bit_flags_unit.sv */
// coprocessor_alu_16bit_flags_unit: top level of the 16-bit flags ALU.
// Depends on cau_pkg; instantiates cau_alu (which holds cau_mul).
//
//   port group   direction  handshake           payload
//   req_         in         start / busy        req_data  (cau_req_type)
//   rsp_         out        rsp_valid strobe    rsp_data  (cau_rsp_type)
//
// A word accepted at one edge is registered in req_ff, goes through cau_alu and the
// 17x17 multiplier, and its result is registered in rsp_ff and shows on rsp_ for one cycle.
// One word per cycle; busy stays low, so nothing ever waits.
// Synchronous reset clears the valid bits only; the receiver cannot stall.
module coprocessor_alu_16bit_flags_unit
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  cau_req_type req_data,
   output logic        rsp_valid,
   output cau_rsp_type rsp_data
);

   cau_req_type req_ff;
   logic        req_valid_ff;
   logic        req_valid_in;
   cau_rsp_type alu_rsp;
   cau_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= alu_rsp;
      end
   end

   cau_alu u_alu (
      .req (req_ff),
      .rsp (alu_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/cau_checker.sv */
// cau_checker: port-level checks on the flags ALU, bound to the top level.
// Depends on cau_pkg and coprocessor_alu_16bit_flags_unit.
module cau_checker
   import cau_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input cau_rsp_type rsp_data
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("accepted word gave no result two cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 2))
      else $error("result without an accepted word");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_lmult_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_low |->
         rsp_data.write_result && (rsp_data.carry_flag == rsp_data.low_product[15]))
      else $error("lmult carry or write enable wrong");

endmodule

bind coprocessor_alu_16bit_flags_unit cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
